@@ rtl/core/bis_pkg.sv @@
// ---------------------------------------------------------------------------
// bis_pkg
// shared widths, command word and state types of the bilinear image scaler
// ---------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  // port field widths
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned NUM_NB     = 4;
  localparam int unsigned PROD_W     = COORD_W + SCALE_W;

  // queue word fields, sized for the largest supported image and fraction
  localparam int unsigned ADDR_MAX_W = 20;
  localparam int unsigned COL_MAX_W  = 10;
  localparam int unsigned DIM_MAX_W  = 11;
  localparam int unsigned FRAC_MAX_W = 24;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_INV_SCALE  = 2'd2
  } cfg_idx_e;

  // one queue word: a pixel write or a classified sample
  typedef struct packed {
    logic                  is_wr;
    logic [ADDR_MAX_W-1:0] addr;   // write address, or row base of a sample
    logic [PIX_W-1:0]      data;
    logic [COL_MAX_W-1:0]  col;
    logic [DIM_MAX_W-1:0]  dim;    // effective width
    logic [NUM_NB-1:0]     inb;    // neighbor inside image: tl, tr, bl, br
    logic [FRAC_MAX_W-1:0] fx;
    logic [FRAC_MAX_W-1:0] fy;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_e;

endpackage

`default_nettype wire

@@ rtl/core/bis_ram.sv @@
// ---------------------------------------------------------------------------
// bis_ram
// single-port ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module bis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/bis_fifo.sv @@
// ---------------------------------------------------------------------------
// bis_fifo
// small register queue, head word shown while not empty
// ---------------------------------------------------------------------------
`default_nettype none

module bis_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));

endmodule

`default_nettype wire

@@ rtl/core/bis_front.sv @@
// ---------------------------------------------------------------------------
// bis_front
// accepts words, scales coordinates and classifies neighbors for the queue
// ---------------------------------------------------------------------------
`default_nettype none

module bis_front #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [bis_pkg::CMD_W-1:0]      command_i,
  input  wire logic [bis_pkg::ADDR_W-1:0]     pixel_address_i,
  input  wire logic [bis_pkg::PIX_W-1:0]      pixel_value_i,
  input  wire logic [bis_pkg::COORD_W-1:0]    dest_x_i,
  input  wire logic [bis_pkg::COORD_W-1:0]    dest_y_i,
  input  wire logic [bis_pkg::DIM_W-1:0]      src_width_i,
  input  wire logic [bis_pkg::DIM_W-1:0]      src_height_i,
  input  wire logic [bis_pkg::SCALE_W-1:0]    inv_scale_i,
  output logic                                q_push_o,
  output bis_pkg::cmd_t                       q_data_o,
  input  wire logic                           q_full_i
);
  import bis_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned XW    = PROD_W - FRAC_BITS;

  // stage 1: accepted word and scaled coordinates
  logic                 s1_vld_q;
  logic                 s1_cmd_q;
  logic [ADDR_W-1:0]    s1_addr_q;
  logic [PIX_W-1:0]     s1_data_q;
  logic [PROD_W-1:0]    s1_px_q, s1_py_q;
  logic [PROD_W-1:0]    px_d, py_d;

  // stage 2: classified queue word
  logic                 s2_vld_q, s2_keep_q;
  cmd_t                 s2_q;
  cmd_t                 s2_d;
  logic                 s2_keep_d;

  logic                 s2_free, s1_free;
  logic [DW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic [XW-1:0]        x0, y0;
  logic                 x0v, x1v, y0v, y1v;
  logic [RW+DW-1:0]     base_full;

  assign px_d = dest_x_i * inv_scale_i;
  assign py_d = dest_y_i * inv_scale_i;

  assign s2_free    = !s2_vld_q || !s2_keep_q || !q_full_i;
  assign s1_free    = !s1_vld_q || s2_free;
  assign in_ready_o = s1_free;

  // image size saturated at the store size
  assign w_eff = DW'((32'(src_width_i) > MAX_WIDTH) ? MAX_WIDTH : 32'(src_width_i));
  assign h_eff = HW'((32'(src_height_i) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(src_height_i));

  assign x0  = s1_px_q[PROD_W-1:FRAC_BITS];
  assign y0  = s1_py_q[PROD_W-1:FRAC_BITS];
  assign x0v = {1'b0, x0} < (XW+1)'(w_eff);
  assign x1v = ((XW+1)'(x0) + 1'b1) < (XW+1)'(w_eff);
  assign y0v = {1'b0, y0} < (XW+1)'(h_eff);
  assign y1v = ((XW+1)'(y0) + 1'b1) < (XW+1)'(h_eff);
  assign base_full = y0[RW-1:0] * w_eff;

  always_comb begin
    s2_d       = '0;
    s2_d.is_wr = (s1_cmd_q == CMD_WRITE);
    s2_d.data  = s1_data_q;
    s2_d.col   = COL_MAX_W'(x0[CW-1:0]);
    s2_d.dim   = DIM_MAX_W'(w_eff);
    s2_d.inb   = {x1v & y1v, x0v & y1v, x1v & y0v, x0v & y0v};
    s2_d.fx    = FRAC_MAX_W'(s1_px_q[FRAC_BITS-1:0]);
    s2_d.fy    = FRAC_MAX_W'(s1_py_q[FRAC_BITS-1:0]);
    if (s2_d.is_wr) begin
      s2_d.addr = ADDR_MAX_W'(s1_addr_q);
    end else begin
      s2_d.addr = ADDR_MAX_W'(AW'(base_full));
    end
    // writes beyond the store are dropped
    s2_keep_d = !s2_d.is_wr || (32'(s1_addr_q) < DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_keep_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_vld_q  <= s1_vld_q;
        s2_keep_q <= s2_keep_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_cmd_q  <= command_i;
      s1_addr_q <= pixel_address_i;
      s1_data_q <= pixel_value_i;
      s1_px_q   <= px_d;
      s1_py_q   <= py_d;
    end
    if (s1_vld_q && s2_free) begin
      s2_q <= s2_d;
    end
  end

  assign q_push_o = s2_vld_q && s2_keep_q && !q_full_i;
  assign q_data_o = s2_q;

endmodule

`default_nettype wire

@@ rtl/core/bis_back.sv @@
// ---------------------------------------------------------------------------
// bis_back
// owns the image ram, fetches four neighbors per sample and blends them
// ---------------------------------------------------------------------------
`default_nettype none

module bis_back #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned OUT_DEPTH  = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  bis_pkg::cmd_t                   q_data_i,
  output logic                            q_pop_o,
  output logic                            out_push_o,
  output logic [bis_pkg::PIX_W-1:0]       out_data_o,
  input  wire logic                       out_pop_i
);
  import bis_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned CRW   = $clog2(OUT_DEPTH + 1);
  localparam int unsigned HSW   = CH_W + FRAC_BITS + 1;
  localparam int unsigned HRW   = CH_W + FRAC_BITS;
  localparam int unsigned VSW   = CH_W + 2 * FRAC_BITS + 1;
  localparam logic [1:0]  PH_LAST = 2'd3;
  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  bk_state_e            state_q, state_d;
  logic [1:0]           ph_q, ph;
  cmd_t                 cur_q, src;
  logic [CRW-1:0]       crd_q;
  logic                 crd_ok, start, wr;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr, rd_addr;
  logic [PIX_W-1:0]     ram_rdata;

  // read tag, registered alongside the ram read data
  logic                 rd_vld, rd_inb;
  logic                 rd_vld_q, rd_inb_q;
  logic [1:0]           rd_idx_q;
  logic [FRAC_BITS-1:0] rd_fx_q, rd_fy_q;

  logic [PIX_W-1:0]     pix_q [NUM_NB];
  logic [FRAC_BITS-1:0] cap_fx_q, cap_fy_q;
  logic                 cap_done_q;

  logic [HSW-1:0]       top_sum [NUM_CH];
  logic [HSW-1:0]       bot_sum [NUM_CH];
  logic [HRW-1:0]       top_q [NUM_CH];
  logic [HRW-1:0]       bot_q [NUM_CH];
  logic [FRAC_BITS-1:0] hz_fy_q;
  logic                 hz_vld_q;
  logic [VSW-1:0]       vt_sum [NUM_CH];
  logic [FRAC_BITS:0]   wx0, wy0;

  assign crd_ok = crd_q < CRW'(OUT_DEPTH);
  assign wr     = (state_q == BK_IDLE) && !q_empty_i && q_data_i.is_wr;
  assign start  = (state_q == BK_IDLE) && !q_empty_i && !q_data_i.is_wr && crd_ok;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (start) state_d = BK_READ;
      BK_READ: if (ph_q == PH_LAST) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs: queue pop, ram port and read tag
  always_comb begin
    src     = q_data_i;
    ph      = 2'd0;
    rd_vld  = start;
    q_pop_o = wr || start;
    case (state_q)
      BK_IDLE: begin
        src = q_data_i;
        ph  = 2'd0;
      end
      BK_READ: begin
        src    = cur_q;
        ph     = ph_q;
        rd_vld = 1'b1;
      end
      default: begin
        src = q_data_i;
        ph  = 2'd0;
      end
    endcase
    rd_addr  = src.addr[AW-1:0] + AW'(src.col[CW-1:0]) + AW'(ph[0])
             + (ph[1] ? AW'(src.dim[DW-1:0]) : '0);
    rd_inb   = src.inb[ph];
    ram_we   = wr;
    ram_addr = wr ? q_data_i.addr[AW-1:0] : rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      ph_q       <= '0;
      crd_q      <= '0;
      rd_vld_q   <= 1'b0;
      cap_done_q <= 1'b0;
      hz_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        ph_q <= 2'd1;
      end else if (state_q == BK_READ) begin
        ph_q <= ph_q + 1'b1;
      end
      if (start && !out_pop_i) begin
        crd_q <= crd_q + 1'b1;
      end else if (out_pop_i && !start) begin
        crd_q <= crd_q - 1'b1;
      end
      rd_vld_q   <= rd_vld;
      cap_done_q <= rd_vld_q && (rd_idx_q == PH_LAST);
      hz_vld_q   <= cap_done_q;
    end
  end

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (q_data_i.data),
    .rdata_o (ram_rdata)
  );

  assign wx0 = FRAC_ONE - {1'b0, cap_fx_q};
  assign wy0 = FRAC_ONE - {1'b0, hz_fy_q};

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      top_sum[c] = HSW'(pix_q[0][c*CH_W +: CH_W]) * HSW'(wx0)
                 + HSW'(pix_q[1][c*CH_W +: CH_W]) * HSW'(cap_fx_q);
      bot_sum[c] = HSW'(pix_q[2][c*CH_W +: CH_W]) * HSW'(wx0)
                 + HSW'(pix_q[3][c*CH_W +: CH_W]) * HSW'(cap_fx_q);
      vt_sum[c]  = VSW'(top_q[c]) * VSW'(wy0) + VSW'(bot_q[c]) * VSW'(hz_fy_q);
      out_data_o[c*CH_W +: CH_W] = vt_sum[c][2*FRAC_BITS +: CH_W];
    end
  end

  assign out_push_o = hz_vld_q;

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q <= q_data_i;
    end
    rd_idx_q <= ph;
    rd_inb_q <= rd_inb;
    rd_fx_q  <= src.fx[FRAC_BITS-1:0];
    rd_fy_q  <= src.fy[FRAC_BITS-1:0];
    if (rd_vld_q) begin
      pix_q[rd_idx_q] <= rd_inb_q ? ram_rdata : '0;
      if (rd_idx_q == PH_LAST) begin
        cap_fx_q <= rd_fx_q;
        cap_fy_q <= rd_fy_q;
      end
    end
    if (cap_done_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        top_q[c] <= top_sum[c][HRW-1:0];
        bot_q[c] <= bot_sum[c][HRW-1:0];
      end
      hz_fy_q <= cap_fy_q;
    end
  end

`ifndef SYNTHESIS
  a_crd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crd_q <= CRW'(OUT_DEPTH))
    else $error("result credits exceed output queue depth");

  a_no_wr_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ) |-> !ram_we)
    else $error("ram write during neighbor fetch");

  a_blend_follows_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hz_vld_q |-> $past(cap_done_q))
    else $error("blend stage without a completed fetch");

  a_push_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> (crd_q != '0))
    else $error("result pushed without a reserved slot");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bilinear_image_scaler.sv @@
// ---------------------------------------------------------------------------
// bilinear_image_scaler
// source image store with bilinear resampling of destination pixels
// ---------------------------------------------------------------------------
// a sample passes the front stages, the command queue, its ram reads and
//   the capture and blend registers before reaching the output queue
// the single-port image ram serves the four neighbor reads one per cycle;
// input side accepts one word per cycle until the 4-word queue fills
// reset clears control state and loads width 64, height 64, step 1.0;
//   image contents are undefined until written, no clearing pass
`default_nettype none

module bilinear_image_scaler #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bis_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input words
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [bis_pkg::CMD_W-1:0]         command_i,
  input  wire logic [bis_pkg::ADDR_W-1:0]        pixel_address_i,
  input  wire logic [bis_pkg::PIX_W-1:0]         pixel_value_i,
  input  wire logic [bis_pkg::COORD_W-1:0]       dest_x_i,
  input  wire logic [bis_pkg::COORD_W-1:0]       dest_y_i,
  // result words
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [bis_pkg::PIX_W-1:0]              scaled_pixel_o
);
  import bis_pkg::*;

  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned CMD_BITS  = $bits(cmd_t);

  // configuration registers
  logic [DIM_W-1:0]   src_width_q, src_height_q;
  logic [SCALE_W-1:0] inv_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DIM_W'(64);
      src_height_q <= DIM_W'(64);
      inv_scale_q  <= SCALE_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_INV_SCALE:  inv_scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept, scale coordinates, classify neighbors
  logic                q_push, q_pop, q_empty, q_full;
  cmd_t                q_wdata, q_head;
  logic [CMD_BITS-1:0] q_rdata;

  bis_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .pixel_address_i (pixel_address_i),
    .pixel_value_i   (pixel_value_i),
    .dest_x_i        (dest_x_i),
    .dest_y_i        (dest_y_i),
    .src_width_i     (src_width_q),
    .src_height_i    (src_height_q),
    .inv_scale_i     (inv_scale_q),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata),
    .q_full_i        (q_full)
  );

  // queue decoupling front and back; writes and samples keep their order
  bis_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign q_head = cmd_t'(q_rdata);

  // back: ram fetch and blend; results only issued with an output slot free
  logic             out_push, out_pop, out_empty, out_full;
  logic [PIX_W-1:0] out_wdata;

  bis_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_head),
    .q_pop_o    (q_pop),
    .out_push_o (out_push),
    .out_data_o (out_wdata),
    .out_pop_i  (out_pop)
  );

  // output queue parts the result side from the blend pipeline
  bis_fifo #(
    .WIDTH (PIX_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .pop_i   (out_pop),
    .rdata_o (scaled_pixel_o),
    .empty_o (out_empty),
    .full_o  (out_full)
  );

  assign out_valid_o = !out_empty;
  assign out_pop     = out_valid_o && out_ready_i;

`ifndef SYNTHESIS
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && out_full) |-> out_pop)
    else $error("result pushed into a full output queue");

  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("word pushed into a full command queue");

  a_cmd_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire
